[sv/closest_point_on_triangle_macros.svh]
// ----------------------------------------------------------------------------
// Closest point on triangle: assertion macros
// Shorthand for the concurrent checks of the port checker.
// ----------------------------------------------------------------------------
`ifndef CLOSEST_POINT_ON_TRIANGLE_MACROS_SVH
`define CLOSEST_POINT_ON_TRIANGLE_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define CPT_ASSERT_COMB(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define CPT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[sv/cpt_pkg.sv]
// ----------------------------------------------------------------------------
// Closest point on triangle: package
// Coordinate format, region codes and the request and response payloads.
// ----------------------------------------------------------------------------
package cpt_pkg;

  localparam int COORD_BITS = 16;
  localparam int QUOT_BITS  = 16;

  localparam logic [2:0] RGN_VTX_A   = 3'd0;
  localparam logic [2:0] RGN_VTX_B   = 3'd1;
  localparam logic [2:0] RGN_EDGE_AB = 3'd2;
  localparam logic [2:0] RGN_VTX_C   = 3'd3;
  localparam logic [2:0] RGN_EDGE_AC = 3'd4;
  localparam logic [2:0] RGN_EDGE_BC = 3'd5;
  localparam logic [2:0] RGN_FACE    = 3'd6;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by_coord;
    coord_t bz;
    coord_t cx;
    coord_t cy;
    coord_t cz;
    coord_t px;
    coord_t py;
    coord_t pz;
  } req_t;

  typedef struct packed {
    coord_t     qx;
    coord_t     qy;
    coord_t     qz;
    logic [2:0] region;
    logic       degenerate;
  } rsp_t;

endpackage

[sv/cpt_div.sv]
// ----------------------------------------------------------------------------
// Closest point on triangle: dual pipelined divider
// Two restoring dividers side by side, one quotient bit per stage, giving
// floor(num * 2^QB / den) for num <= den. A sideband word travels along.
// ----------------------------------------------------------------------------
module cpt_div #(
  parameter int DW = 75,
  parameter int QB = 16,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [DW-1:0] num1,
  input  logic [DW-1:0] den1,
  input  logic [DW-1:0] num2,
  input  logic [DW-1:0] den2,
  input  logic [SW-1:0] side_in,
  output logic          out_vld,
  output logic [QB:0]   q1,
  output logic [QB:0]   q2,
  output logic [SW-1:0] side_out
);

  localparam int NS = QB + 1;

  logic [NS-1:0] vld_r;
  logic [DW-1:0] rem1_r [NS];
  logic [DW-1:0] rem2_r [NS];
  logic [DW-1:0] den1_r [NS];
  logic [DW-1:0] den2_r [NS];
  logic [QB:0]   quo1_r [NS];
  logic [QB:0]   quo2_r [NS];
  logic [SW-1:0] side_r [NS];

  logic [DW:0]   rs1 [NS];
  logic [DW:0]   rs2 [NS];
  logic [DW-1:0] dd1 [NS];
  logic [DW-1:0] dd2 [NS];
  logic [QB:0]   qp1 [NS];
  logic [QB:0]   qp2 [NS];
  logic [SW-1:0] sd  [NS];
  logic [NS-1:0] vd;
  logic [NS-1:0] ge1;
  logic [NS-1:0] ge2;

  // Stage inputs: the first stage takes the operands, later ones the
  // doubled remainder of the stage before.
  always_comb begin
    for (int j = 0; j < NS; j++) begin
      if (j == 0) begin
        rs1[j] = {1'b0, num1};
        rs2[j] = {1'b0, num2};
        dd1[j] = den1;
        dd2[j] = den2;
        qp1[j] = '0;
        qp2[j] = '0;
        sd[j]  = side_in;
        vd[j]  = in_vld;
      end else begin
        rs1[j] = {rem1_r[j-1], 1'b0};
        rs2[j] = {rem2_r[j-1], 1'b0};
        dd1[j] = den1_r[j-1];
        dd2[j] = den2_r[j-1];
        qp1[j] = quo1_r[j-1];
        qp2[j] = quo2_r[j-1];
        sd[j]  = side_r[j-1];
        vd[j]  = vld_r[j-1];
      end
      ge1[j] = rs1[j] >= {1'b0, dd1[j]};
      ge2[j] = rs2[j] >= {1'b0, dd2[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NS; j++) begin
        rem1_r[j] <= ge1[j] ? DW'(rs1[j] - {1'b0, dd1[j]}) : DW'(rs1[j]);
        rem2_r[j] <= ge2[j] ? DW'(rs2[j] - {1'b0, dd2[j]}) : DW'(rs2[j]);
        den1_r[j] <= dd1[j];
        den2_r[j] <= dd2[j];
        quo1_r[j] <= {qp1[j][QB-1:0], ge1[j]};
        quo2_r[j] <= {qp2[j][QB-1:0], ge2[j]};
        side_r[j] <= sd[j];
      end
    end
  end

  assign out_vld  = vld_r[NS-1];
  assign q1       = quo1_r[NS-1];
  assign q2       = quo2_r[NS-1];
  assign side_out = side_r[NS-1];

endmodule

[sv/closest_point_on_triangle.sv]
// ----------------------------------------------------------------------------
// Closest point on triangle
// Finds the point of triangle ABC closest to a query point P by Voronoi
// region tests, in a fully pipelined datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel in_valid / in_stall / in_data carries A, B, C and P as
//   signed fixed-point coordinates. Response channel out_valid / out_stall /
//   out_data returns the closest point, the region code and a flag that is
//   set when the region's divisor was zero (vertex A is returned then).
//   A request is taken at a clock edge where valid is high and stall is low.
// Throughput: one request per cycle, back to back, while no held response
//   stalls the pipeline; no dependence between requests.
// Pipeline: the two pipelined dividers make up most of the stages: one
//   quotient bit per stage, QUOT_BITS + 1 stages. The remaining stages are
//   differences, dot products, split wide products, cross terms, region
//   select, the fraction-times-edge products, rounding and saturation.
// Stall: the whole pipeline advances together. A stalled response holds the
//   pipeline and in_stall rises in the same cycle; nothing is lost or
//   repeated. With the output register empty or draining, requests flow.
// Reset: synchronous, active low, clears every valid bit; the block is ready
//   in the first cycle after reset.
// ----------------------------------------------------------------------------
module closest_point_on_triangle #(
  parameter int QUOT_BITS = cpt_pkg::QUOT_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cpt_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cpt_pkg::rsp_t out_data
);

  // Widths of the datapath, derived from the coordinate width and QUOT_BITS.
  localparam int CW   = cpt_pkg::COORD_BITS;
  localparam int DFW  = CW + 1;            // vertex difference
  localparam int PW   = 2 * DFW;           // one term of a dot product
  localparam int DTW  = PW + 2;            // dot product
  localparam int EVW  = DTW + 2;           // dot differences and sums
  localparam int LW   = DTW / 2;           // low half of a split operand
  localparam int HWD  = DTW - LW;          // high half of a split operand
  localparam int MW   = 2 * DTW;           // product of two dot products
  localparam int VW   = MW + 1;            // barycentric cross term
  localparam int DW   = VW + 2;            // divider operand
  localparam int QW   = QUOT_BITS + 1;     // quotient, fraction in [0,1]
  localparam int EPW  = DFW + QW + 1;      // edge times fraction
  localparam int TW   = EPW + 1;           // sum of two such products
  localparam int TSW  = TW - QUOT_BITS;    // after the rounding shift
  localparam int OW   = TSW + 1;           // plus the base vertex

  localparam logic signed [TW-1:0] RND  = TW'(1) <<< (QUOT_BITS - 1);
  localparam logic signed [OW-1:0] CMAX = OW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [OW-1:0] CMIN = -CMAX - OW'(1);

  // Operand pairs of the six cross products:
  // d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
  localparam int PA [6] = '{0, 2, 4, 0, 2, 4};
  localparam int PB [6] = '{3, 1, 1, 5, 5, 3};

  typedef logic signed [DFW-1:0] dif_t;
  typedef logic signed [DTW-1:0] dot_t;
  typedef logic signed [EVW-1:0] ev_t;

  typedef struct packed {
    cpt_pkg::coord_t [2:0] a;
    cpt_pkg::coord_t [2:0] b;
    dif_t [2:0]            ab;
    dif_t [2:0]            ac;
    dif_t [2:0]            bc;
  } geo_t;

  typedef struct packed {
    logic vtx_a;
    logic vtx_b;
    logic vtx_c;
    logic d1_ge0;
    logic d2_ge0;
    logic d3_le0;
    logic d6_le0;
    logic e43_ge0;
    logic e56_ge0;
  } flg_t;

  typedef struct packed {
    ev_t n_ab;
    ev_t d_ab;
    ev_t n_ac;
    ev_t d_ac;
    ev_t n_bc;
    ev_t d_bc;
  } edv_t;

  typedef struct packed {
    cpt_pkg::coord_t [2:0] base;
    dif_t [2:0]            e1;
    dif_t [2:0]            e2;
    logic [2:0]            region;
    logic                  degen;
  } sel_t;

  typedef struct packed {
    cpt_pkg::coord_t [2:0] base;
    logic [2:0]            region;
    logic                  degen;
  } tail_t;

  localparam int SW = $bits(sel_t);

  // Pipeline enable: advance unless a finished response is held.
  logic en;

  // Stage 1: coordinates and differences.
  logic [7:1]      vld_r;
  geo_t            geo_nxt;
  geo_t            geo_r [1:6];
  cpt_pkg::coord_t cin   [3];
  cpt_pkg::coord_t pin   [3];
  dif_t            ap_nxt [3];
  dif_t            bp_nxt [3];
  dif_t            cp_nxt [3];
  dif_t            ap_r [3];
  dif_t            bp_r [3];
  dif_t            cp_r [3];

  // Stages 2 to 6: dot products and cross terms.
  logic signed [PW-1:0]    prod_r [6][3];
  dot_t                    d_r [6];
  logic [2*LW-1:0]         ll_r [6];
  logic signed [LW+HWD:0]  lh_r [6];
  logic signed [LW+HWD:0]  hl_r [6];
  logic signed [2*HWD-1:0] hh_r [6];
  flg_t                    flg_nxt;
  edv_t                    edv_nxt;
  flg_t                    flg_r [4:6];
  edv_t                    edv_r [4:6];
  ev_t                     e43;
  ev_t                     e56;
  logic signed [MW-1:0]    m_r [6];
  logic signed [VW-1:0]    va_r;
  logic signed [VW-1:0]    vb_r;
  logic signed [VW-1:0]    vc_r;

  // Stage 7: region select and divider operands.
  logic signed [DW-1:0] vsum;
  logic [DW-1:0]        num1_nxt;
  logic [DW-1:0]        den1_nxt;
  logic [DW-1:0]        num2_nxt;
  logic [DW-1:0]        num1_r;
  logic [DW-1:0]        den1_r;
  logic [DW-1:0]        num2_r;
  logic [DW-1:0]        den2_r;
  sel_t                 sel_nxt;
  sel_t                 sel_r;

  // Divider outputs.
  logic                 div_vld;
  logic [QW-1:0]        q1;
  logic [QW-1:0]        q2;
  logic [SW-1:0]        side_o;
  sel_t                 dsel;
  logic signed [QW:0]   qs1;
  logic signed [QW:0]   qs2;

  // Back end: products, rounding, saturation.
  logic                  vm_r;
  logic                  vr_r;
  logic                  out_vld_r;
  logic signed [EPW-1:0] pm1_r [3];
  logic signed [EPW-1:0] pm2_r [3];
  tail_t                 tm_r;
  tail_t                 tr_r;
  logic signed [TW-1:0]  tsum [3];
  logic signed [TSW-1:0] ts_r [3];
  logic signed [OW-1:0]  osum [3];
  cpt_pkg::coord_t       qsat [3];
  cpt_pkg::rsp_t         out_r;

  assign en       = !out_vld_r || !out_stall;
  assign in_stall = !en;

  // ---- Stage 1: unpack the request and form the edge and point vectors.
  always_comb begin
    geo_nxt.a[0] = in_data.ax;
    geo_nxt.a[1] = in_data.ay;
    geo_nxt.a[2] = in_data.az;
    geo_nxt.b[0] = in_data.bx;
    geo_nxt.b[1] = in_data.by_coord;
    geo_nxt.b[2] = in_data.bz;
    cin[0]       = in_data.cx;
    cin[1]       = in_data.cy;
    cin[2]       = in_data.cz;
    pin[0]       = in_data.px;
    pin[1]       = in_data.py;
    pin[2]       = in_data.pz;
    for (int k = 0; k < 3; k++) begin
      geo_nxt.ab[k] = DFW'(geo_nxt.b[k]) - DFW'(geo_nxt.a[k]);
      geo_nxt.ac[k] = DFW'(cin[k]) - DFW'(geo_nxt.a[k]);
      geo_nxt.bc[k] = DFW'(cin[k]) - DFW'(geo_nxt.b[k]);
      ap_nxt[k]     = DFW'(pin[k]) - DFW'(geo_nxt.a[k]);
      bp_nxt[k]     = DFW'(pin[k]) - DFW'(geo_nxt.b[k]);
      cp_nxt[k]     = DFW'(pin[k]) - DFW'(cin[k]);
    end
  end

  // ---- Stage 4 side logic: vertex tests and edge fractions from the dots.
  always_comb begin
    e43             = EVW'(d_r[3]) - EVW'(d_r[2]);
    e56             = EVW'(d_r[4]) - EVW'(d_r[5]);
    flg_nxt.vtx_a   = (d_r[0] <= 0) && (d_r[1] <= 0);
    flg_nxt.vtx_b   = (d_r[2] >= 0) && (e43 <= 0);
    flg_nxt.vtx_c   = (d_r[5] >= 0) && (e56 <= 0);
    flg_nxt.d1_ge0  = d_r[0] >= 0;
    flg_nxt.d2_ge0  = d_r[1] >= 0;
    flg_nxt.d3_le0  = d_r[2] <= 0;
    flg_nxt.d6_le0  = d_r[5] <= 0;
    flg_nxt.e43_ge0 = e43 >= 0;
    flg_nxt.e56_ge0 = e56 >= 0;
    edv_nxt.n_ab    = EVW'(d_r[0]);
    edv_nxt.d_ab    = EVW'(d_r[0]) - EVW'(d_r[2]);
    edv_nxt.n_ac    = EVW'(d_r[1]);
    edv_nxt.d_ac    = EVW'(d_r[1]) - EVW'(d_r[5]);
    edv_nxt.n_bc    = e43;
    edv_nxt.d_bc    = e43 + e56;
  end

  // ---- Stage 7: pick the region in test order and set up the divisions.
  always_comb begin
    vsum          = DW'(va_r) + DW'(vb_r) + DW'(vc_r);
    sel_nxt.base  = geo_r[6].a;
    sel_nxt.e1    = geo_r[6].ab;
    sel_nxt.e2    = geo_r[6].ac;
    sel_nxt.degen = 1'b0;
    num1_nxt      = DW'(vb_r);
    num2_nxt      = DW'(vc_r);
    den1_nxt      = vsum;
    if (flg_r[6].vtx_a) begin
      sel_nxt.region = cpt_pkg::RGN_VTX_A;
    end else if (flg_r[6].vtx_b) begin
      sel_nxt.region = cpt_pkg::RGN_VTX_B;
      sel_nxt.base   = geo_r[6].b;
    end else if ((vc_r <= 0) && flg_r[6].d1_ge0 && flg_r[6].d3_le0) begin
      sel_nxt.region = cpt_pkg::RGN_EDGE_AB;
      sel_nxt.e2     = '0;
      num1_nxt       = DW'(edv_r[6].n_ab);
      den1_nxt       = DW'(edv_r[6].d_ab);
    end else if (flg_r[6].vtx_c) begin
      sel_nxt.region = cpt_pkg::RGN_VTX_C;
      for (int k = 0; k < 3; k++) begin
        sel_nxt.base[k] = cpt_pkg::coord_t'(geo_r[6].a[k] + geo_r[6].ac[k]);
      end
    end else if ((vb_r <= 0) && flg_r[6].d2_ge0 && flg_r[6].d6_le0) begin
      sel_nxt.region = cpt_pkg::RGN_EDGE_AC;
      sel_nxt.e1     = geo_r[6].ac;
      sel_nxt.e2     = '0;
      num1_nxt       = DW'(edv_r[6].n_ac);
      den1_nxt       = DW'(edv_r[6].d_ac);
    end else if ((va_r <= 0) && flg_r[6].e43_ge0 && flg_r[6].e56_ge0) begin
      sel_nxt.region = cpt_pkg::RGN_EDGE_BC;
      sel_nxt.base   = geo_r[6].b;
      sel_nxt.e1     = geo_r[6].bc;
      sel_nxt.e2     = '0;
      num1_nxt       = DW'(edv_r[6].n_bc);
      den1_nxt       = DW'(edv_r[6].d_bc);
    end else begin
      sel_nxt.region = cpt_pkg::RGN_FACE;
    end

    // Vertex regions use no fraction; a zero divisor falls back to vertex A.
    if ((sel_nxt.region == cpt_pkg::RGN_VTX_A) || (sel_nxt.region == cpt_pkg::RGN_VTX_B) ||
        (sel_nxt.region == cpt_pkg::RGN_VTX_C)) begin
      sel_nxt.e1 = '0;
      sel_nxt.e2 = '0;
    end else if (den1_nxt == '0) begin
      sel_nxt.degen = 1'b1;
      sel_nxt.base  = geo_r[6].a;
      sel_nxt.e1    = '0;
      sel_nxt.e2    = '0;
    end
  end

  // ---- Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      vm_r      <= 1'b0;
      vr_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[6:1], in_valid};
      vm_r      <= div_vld;
      vr_r      <= vm_r;
      out_vld_r <= vr_r;
    end
  end

  // ---- Front datapath, stages 1 to 7. Hold everything while stalled.
  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1
      geo_r[1] <= geo_nxt;
      for (int k = 0; k < 3; k++) begin
        ap_r[k] <= ap_nxt[k];
        bp_r[k] <= bp_nxt[k];
        cp_r[k] <= cp_nxt[k];
      end
      for (int s = 2; s <= 6; s++) begin
        geo_r[s] <= geo_r[s-1];
      end

      // Stage 2: terms of d1..d6
      for (int k = 0; k < 3; k++) begin
        prod_r[0][k] <= PW'(geo_r[1].ab[k]) * PW'(ap_r[k]);
        prod_r[1][k] <= PW'(geo_r[1].ac[k]) * PW'(ap_r[k]);
        prod_r[2][k] <= PW'(geo_r[1].ab[k]) * PW'(bp_r[k]);
        prod_r[3][k] <= PW'(geo_r[1].ac[k]) * PW'(bp_r[k]);
        prod_r[4][k] <= PW'(geo_r[1].ab[k]) * PW'(cp_r[k]);
        prod_r[5][k] <= PW'(geo_r[1].ac[k]) * PW'(cp_r[k]);
      end

      // Stage 3: sum the terms
      for (int i = 0; i < 6; i++) begin
        d_r[i] <= DTW'(prod_r[i][0]) + DTW'(prod_r[i][1]) + DTW'(prod_r[i][2]);
      end

      // Stage 4: split each wide product into four partial products
      for (int i = 0; i < 6; i++) begin
        ll_r[i] <= (2*LW)'(d_r[PA[i]][LW-1:0]) * (2*LW)'(d_r[PB[i]][LW-1:0]);
        lh_r[i] <= (LW+HWD+1)'($signed({1'b0, d_r[PA[i]][LW-1:0]})) *
                   (LW+HWD+1)'($signed(d_r[PB[i]][DTW-1:LW]));
        hl_r[i] <= (LW+HWD+1)'($signed(d_r[PA[i]][DTW-1:LW])) *
                   (LW+HWD+1)'($signed({1'b0, d_r[PB[i]][LW-1:0]}));
        hh_r[i] <= (2*HWD)'($signed(d_r[PA[i]][DTW-1:LW])) *
                   (2*HWD)'($signed(d_r[PB[i]][DTW-1:LW]));
      end
      flg_r[4] <= flg_nxt;
      edv_r[4] <= edv_nxt;
      for (int s = 5; s <= 6; s++) begin
        flg_r[s] <= flg_r[s-1];
        edv_r[s] <= edv_r[s-1];
      end

      // Stage 5: recombine the partial products
      for (int i = 0; i < 6; i++) begin
        m_r[i] <= (MW'(hh_r[i]) <<< (2 * LW)) + (MW'(lh_r[i]) <<< LW) +
                  (MW'(hl_r[i]) <<< LW) + MW'($signed({1'b0, ll_r[i]}));
      end

      // Stage 6: barycentric cross terms
      vc_r <= VW'(m_r[0]) - VW'(m_r[1]);
      vb_r <= VW'(m_r[2]) - VW'(m_r[3]);
      va_r <= VW'(m_r[4]) - VW'(m_r[5]);

      // Stage 7
      num1_r <= num1_nxt;
      den1_r <= den1_nxt;
      num2_r <= num2_nxt;
      den2_r <= vsum;
      sel_r  <= sel_nxt;
    end
  end

  // ---- Fractions: one quotient bit per stage in both dividers.
  cpt_div #(
    .DW (DW),
    .QB (QUOT_BITS),
    .SW (SW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld_r[7]),
    .num1     (num1_r),
    .den1     (den1_r),
    .num2     (num2_r),
    .den2     (den2_r),
    .side_in  (sel_r),
    .out_vld  (div_vld),
    .q1       (q1),
    .q2       (q2),
    .side_out (side_o)
  );

  assign dsel = side_o;
  assign qs1  = $signed({1'b0, q1});
  assign qs2  = $signed({1'b0, q2});

  // ---- Back end: round to nearest, add the base vertex and saturate.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tsum[k] = TW'(pm1_r[k]) + TW'(pm2_r[k]) + RND;
      osum[k] = OW'(ts_r[k]) + OW'(tr_r.base[k]);
      if (osum[k] > CMAX) begin
        qsat[k] = cpt_pkg::coord_t'(CMAX);
      end else if (osum[k] < CMIN) begin
        qsat[k] = cpt_pkg::coord_t'(CMIN);
      end else begin
        qsat[k] = cpt_pkg::coord_t'(osum[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pm1_r[k] <= EPW'(dsel.e1[k]) * EPW'(qs1);
        pm2_r[k] <= EPW'(dsel.e2[k]) * EPW'(qs2);
        ts_r[k]  <= tsum[k][TW-1:QUOT_BITS];
      end
      tm_r.base   <= dsel.base;
      tm_r.region <= dsel.region;
      tm_r.degen  <= dsel.degen;
      tr_r        <= tm_r;

      out_r.qx         <= qsat[0];
      out_r.qy         <= qsat[1];
      out_r.qz         <= qsat[2];
      out_r.region     <= tr_r.region;
      out_r.degenerate <= tr_r.degen;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

[sv/cpt_chk.sv]
// ----------------------------------------------------------------------------
// Closest point on triangle: port checker
// Watches the request and response ports and is bound to the top level.
// ----------------------------------------------------------------------------
`include "closest_point_on_triangle_macros.svh"

module cpt_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input cpt_pkg::req_t in_data,
  input logic          out_valid,
  input logic          out_stall,
  input cpt_pkg::rsp_t out_data
);

  logic in_held;
  logic out_held;
  logic region_ok;
  logic degen_ok;

  assign in_held   = in_valid && in_stall;
  assign out_held  = out_valid && out_stall;
  assign region_ok = !out_valid || (out_data.region <= cpt_pkg::RGN_FACE);

  // A zero divisor only arises on an edge or the face.
  assign degen_ok = !(out_valid && out_data.degenerate) ||
                    (out_data.region == cpt_pkg::RGN_EDGE_AB) ||
                    (out_data.region == cpt_pkg::RGN_EDGE_AC) ||
                    (out_data.region == cpt_pkg::RGN_EDGE_BC) ||
                    (out_data.region == cpt_pkg::RGN_FACE);

  // A held request keeps its value.
  `CPT_ASSERT_NEXT(a_in_hold, in_held, in_valid && $stable(in_data), "held request changed")

  // A held response keeps its value.
  `CPT_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_data), "held response changed")

  // The pipeline stalls exactly when a response is held.
  `CPT_ASSERT_COMB(a_stall_link, in_stall == out_held, "request stall does not follow response")

  // Region codes stay within the seven regions.
  `CPT_ASSERT_COMB(a_region_range, region_ok, "region code out of range")

  `CPT_ASSERT_COMB(a_degen_region, degen_ok, "degenerate flag on a vertex region")

endmodule

bind closest_point_on_triangle cpt_chk u_cpt_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[dv/closest_point_on_triangle_test.sv]
// ----------------------------------------------------------------------------
// Closest point on triangle: block-level test
// Streams triangle/point requests through the pipeline under random sender
// bursts and receiver stalls, predicts every response in wide integer
// arithmetic and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module closest_point_on_triangle_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Wide enough for the cross terms, the shifted numerators and the
  // fraction-times-edge products without any overflow.
  typedef logic signed [255:0] wint_t;
  typedef wint_t vec3_t [3];

  localparam int    TIMEOUT_CYCLES = 300000;
  localparam int    DRAIN_CYCLES   = 3 * (cpt_pkg::QUOT_BITS + 10);
  localparam wint_t HALF_LSB       = wint_t'(1) <<< (cpt_pkg::QUOT_BITS - 1);

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  cpt_pkg::req_t  in_data;
  logic           out_valid;
  logic           out_stall;
  cpt_pkg::rsp_t  out_data;

  cpt_pkg::rsp_t  expected_rsp_q[$];
  int             mismatch_cnt;
  int             req_cnt;
  int             rsp_cnt;
  int             cycle_cnt;
  int             region_seen[7];
  int             burst_left;
  int             stall_mode;

  closest_point_on_triangle u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic wint_t dot3(vec3_t u, vec3_t v);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  function automatic cpt_pkg::coord_t saturate_coord(wint_t v);
    wint_t hi;
    wint_t lo;
    hi = (wint_t'(1) <<< (cpt_pkg::COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return cpt_pkg::coord_t'(hi);
    if (v < lo) return cpt_pkg::coord_t'(lo);
    return cpt_pkg::coord_t'(v);
  endfunction

  // base + round(e1*q1 + e2*q2), per coordinate, saturated
  function automatic void place_point(inout cpt_pkg::rsp_t o, input vec3_t base,
                                      input vec3_t e1, input wint_t q1,
                                      input vec3_t e2, input wint_t q2);
    wint_t t[3];
    for (int k = 0; k < 3; k++) begin
      t[k] = ((e1[k] * q1 + e2[k] * q2 + HALF_LSB) >>> cpt_pkg::QUOT_BITS) + base[k];
    end
    o.qx = saturate_coord(t[0]);
    o.qy = saturate_coord(t[1]);
    o.qz = saturate_coord(t[2]);
  endfunction

  function automatic void place_vertex(inout cpt_pkg::rsp_t o, input vec3_t v);
    o.qx = saturate_coord(v[0]);
    o.qy = saturate_coord(v[1]);
    o.qz = saturate_coord(v[2]);
  endfunction

  // Truncating fraction num/den with QUOT_BITS fraction bits.
  function automatic wint_t fraction(wint_t num, wint_t den);
    return (num <<< cpt_pkg::QUOT_BITS) / den;
  endfunction

  function automatic cpt_pkg::rsp_t predict_closest(cpt_pkg::req_t r);
    vec3_t a, b, c, p, ab, ac, bc, ap, bp, cp, zv;
    wint_t d1, d2, d3, d4, d5, d6, va, vb, vc, e43, e56, den, den2, zero;
    cpt_pkg::rsp_t o;
    a = '{wint_t'(r.ax), wint_t'(r.ay), wint_t'(r.az)};
    b = '{wint_t'(r.bx), wint_t'(r.by_coord), wint_t'(r.bz)};
    c = '{wint_t'(r.cx), wint_t'(r.cy), wint_t'(r.cz)};
    p = '{wint_t'(r.px), wint_t'(r.py), wint_t'(r.pz)};
    zero = '0;
    for (int k = 0; k < 3; k++) begin
      ab[k] = b[k] - a[k];
      ac[k] = c[k] - a[k];
      bc[k] = c[k] - b[k];
      ap[k] = p[k] - a[k];
      bp[k] = p[k] - b[k];
      cp[k] = p[k] - c[k];
      zv[k] = zero;
    end
    o = '0;
    d1 = dot3(ab, ap);
    d2 = dot3(ac, ap);
    if (d1 <= 0 && d2 <= 0) begin
      place_vertex(o, a);
      o.region = cpt_pkg::RGN_VTX_A;
      return o;
    end
    d3 = dot3(ab, bp);
    d4 = dot3(ac, bp);
    if (d3 >= 0 && d4 - d3 <= 0) begin
      place_vertex(o, b);
      o.region = cpt_pkg::RGN_VTX_B;
      return o;
    end
    vc = d1 * d4 - d3 * d2;
    if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      o.region = cpt_pkg::RGN_EDGE_AB;
      den = d1 - d3;
      if (den != 0) place_point(o, a, ab, fraction(d1, den), zv, zero);
      else begin
        place_vertex(o, a);
        o.degenerate = 1'b1;
      end
      return o;
    end
    d5 = dot3(ab, cp);
    d6 = dot3(ac, cp);
    if (d6 >= 0 && d5 - d6 <= 0) begin
      place_vertex(o, c);
      o.region = cpt_pkg::RGN_VTX_C;
      return o;
    end
    vb = d5 * d2 - d1 * d6;
    if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      o.region = cpt_pkg::RGN_EDGE_AC;
      den = d2 - d6;
      if (den != 0) place_point(o, a, ac, fraction(d2, den), zv, zero);
      else begin
        place_vertex(o, a);
        o.degenerate = 1'b1;
      end
      return o;
    end
    va = d3 * d6 - d5 * d4;
    e43 = d4 - d3;
    e56 = d5 - d6;
    if (va <= 0 && e43 >= 0 && e56 >= 0) begin
      o.region = cpt_pkg::RGN_EDGE_BC;
      den = e43 + e56;
      if (den != 0) place_point(o, b, bc, fraction(e43, den), zv, zero);
      else begin
        place_vertex(o, a);
        o.degenerate = 1'b1;
      end
      return o;
    end
    o.region = cpt_pkg::RGN_FACE;
    den2 = va + vb + vc;
    if (den2 != 0) place_point(o, a, ab, fraction(vb, den2), ac, fraction(vc, den2));
    else begin
      place_vertex(o, a);
      o.degenerate = 1'b1;
    end
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Response checker and receiver stall pattern
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      // Check what was accepted at this edge, using pre-edge values.
      if (out_valid && !out_stall) begin
        if (expected_rsp_q.size() == 0) begin
          $error("unexpected response: qx %0d qy %0d qz %0d region %0d",
                 out_data.qx, out_data.qy, out_data.qz, out_data.region);
          mismatch_cnt++;
        end else begin
          cpt_pkg::rsp_t exp_rsp;
          exp_rsp = expected_rsp_q.pop_front();
          rsp_cnt++;
          if (out_data.qx !== exp_rsp.qx) begin
            $error("qx: expected %0d, got %0d", exp_rsp.qx, out_data.qx);
            mismatch_cnt++;
          end
          if (out_data.qy !== exp_rsp.qy) begin
            $error("qy: expected %0d, got %0d", exp_rsp.qy, out_data.qy);
            mismatch_cnt++;
          end
          if (out_data.qz !== exp_rsp.qz) begin
            $error("qz: expected %0d, got %0d", exp_rsp.qz, out_data.qz);
            mismatch_cnt++;
          end
          if (out_data.region !== exp_rsp.region) begin
            $error("region: expected %0d, got %0d", exp_rsp.region, out_data.region);
            mismatch_cnt++;
          end
          if (out_data.degenerate !== exp_rsp.degenerate) begin
            $error("degenerate: expected %0d, got %0d", exp_rsp.degenerate,
                   out_data.degenerate);
            mismatch_cnt++;
          end
        end
      end
      // Stall behavior, picked at random: none, light, periodic, heavy.
      if (cycle_cnt % 128 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        2: begin
          out_stall <= ((cycle_cnt % 7) < 3);
        end
        default: begin
          out_stall <= ($urandom_range(0, 9) < 7);
        end
      endcase
    end
  end

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycle_cnt,
               expected_rsp_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Present one request and hold it until accepted. Between bursts, valid
  // may drop for a random gap.
  task automatic send_request(cpt_pkg::req_t r);
    int            gap;
    cpt_pkg::rsp_t exp_rsp;
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    exp_rsp = predict_closest(r);
    expected_rsp_q = {expected_rsp_q, exp_rsp};
    region_seen[exp_rsp.region]++;
    req_cnt++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 8);
      gap = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off the sender until every outstanding response has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_rsp_q.size() != 0) @(posedge clk);
  endtask

  function automatic cpt_pkg::req_t make_req(int ax, int ay, int az, int bx, int by, int bz,
                                             int cx, int cy, int cz, int px, int py, int pz);
    cpt_pkg::req_t r;
    r = '{cpt_pkg::coord_t'(ax), cpt_pkg::coord_t'(ay), cpt_pkg::coord_t'(az),
          cpt_pkg::coord_t'(bx), cpt_pkg::coord_t'(by), cpt_pkg::coord_t'(bz),
          cpt_pkg::coord_t'(cx), cpt_pkg::coord_t'(cy), cpt_pkg::coord_t'(cz),
          cpt_pkg::coord_t'(px), cpt_pkg::coord_t'(py), cpt_pkg::coord_t'(pz)};
    return r;
  endfunction

  function automatic cpt_pkg::coord_t near_coord(cpt_pkg::coord_t center, int spread);
    return cpt_pkg::coord_t'(int'(center) + $urandom_range(0, 2 * spread) - spread);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // One query per region on a right triangle, then the zero-divisor and
  // extreme-coordinate cases.
  task automatic test_directed();
    send_request(make_req(0, 0, 0, 256, 0, 0, 0, 256, 0, -100, -100, 0));
    send_request(make_req(0, 0, 0, 256, 0, 0, 0, 256, 0, 400, -10, 0));
    send_request(make_req(0, 0, 0, 256, 0, 0, 0, 256, 0, 128, -50, 9));
    send_request(make_req(0, 0, 0, 256, 0, 0, 0, 256, 0, -10, 400, 0));
    send_request(make_req(0, 0, 0, 256, 0, 0, 0, 256, 0, -50, 128, -3));
    send_request(make_req(0, 0, 0, 256, 0, 0, 0, 256, 0, 300, 300, 0));
    send_request(make_req(0, 0, 0, 256, 0, 0, 0, 256, 0, 50, 50, 77));
    send_request(make_req(0, 0, 0, 255, 0, 0, 0, 255, 0, 85, 85, 0));
    // Coincident A and B: zero divisor on edge AB.
    send_request(make_req(0, 0, 0, 0, 0, 0, 256, 0, 0, 100, 0, 0));
    // Coincident A and C: the query falls on edge AB with a nonzero divisor.
    send_request(make_req(0, 0, 0, 256, 0, 0, 0, 0, 0, 100, 5, 0));
    // All three vertices equal.
    send_request(make_req(7, -7, 7, 7, -7, 7, 7, -7, 7, 1000, 2000, -3000));
    // Collinear triangles, zero face area.
    send_request(make_req(0, 0, 0, 256, 0, 0, 512, 0, 0, 100, 50, 0));
    send_request(make_req(0, 0, 0, 512, 0, 0, 256, 0, 0, 300, -40, 0));
    // Coordinate extremes and saturation.
    send_request(make_req(32767, 32767, 32767, -32768, -32768, -32768, 32767, -32768, 0,
                          0, 0, 0));
    send_request(make_req(-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, 32767,
                          32767, -32768, 32767));
    send_request(make_req(-32768, 0, 0, 32767, 0, 0, 0, 32767, 0, 0, -32768, 0));
    send_request(make_req(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                          -32768, -32768, -32768));
    send_request(make_req(-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0,
                          20000, 20000, -32768));
    send_request(make_req(-1, -1, -1, 1, 0, 0, 0, 1, 0, 0, 0, 32767));
  endtask

  // Random triangles: mostly compact ones around a random point so all
  // regions show up, plus fully random coordinates and sliver or
  // coincident-vertex cases.
  task automatic test_random_triangles(int count);
    cpt_pkg::req_t   r;
    cpt_pkg::coord_t ctr[3];
    int              spread;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          r = cpt_pkg::req_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        end
        2: begin
          spread = $urandom_range(1, 300);
          for (int k = 0; k < 3; k++) ctr[k] = cpt_pkg::coord_t'($urandom);
          r = make_req(ctr[0], ctr[1], ctr[2],
                       near_coord(ctr[0], spread), near_coord(ctr[1], spread), ctr[2],
                       ctr[0], ctr[1], ctr[2],
                       near_coord(ctr[0], 2 * spread), near_coord(ctr[1], 2 * spread),
                       near_coord(ctr[2], spread));
          // Make one vertex coincide with another, or line all three up.
          case ($urandom_range(0, 2))
            0: {r.cx, r.cy, r.cz} = {r.bx, r.by_coord, r.bz};
            1: {r.bx, r.by_coord, r.bz} = {r.ax, r.ay, r.az};
            default: {r.cx, r.cy, r.cz} = {cpt_pkg::coord_t'(2 * r.bx - r.ax),
                                           cpt_pkg::coord_t'(2 * r.by_coord - r.ay),
                                           cpt_pkg::coord_t'(2 * r.bz - r.az)};
          endcase
        end
        default: begin
          spread = $urandom_range(0, 3) == 0 ? 12000 : $urandom_range(4, 2000);
          for (int k = 0; k < 3; k++) begin
            ctr[k] = cpt_pkg::coord_t'($urandom_range(0, 40000) - 20000);
          end
          r = make_req(near_coord(ctr[0], spread), near_coord(ctr[1], spread),
                       near_coord(ctr[2], spread), near_coord(ctr[0], spread),
                       near_coord(ctr[1], spread), near_coord(ctr[2], spread),
                       near_coord(ctr[0], spread), near_coord(ctr[1], spread),
                       near_coord(ctr[2], spread), near_coord(ctr[0], 2 * spread),
                       near_coord(ctr[1], 2 * spread), near_coord(ctr[2], 2 * spread));
        end
      endcase
      send_request(r);
    end
  endtask

  // Back-to-back requests after a full drain, then another drain.
  task automatic test_drain_and_restart();
    wait_drained();
    burst_left = 40;
    test_random_triangles(40);
    wait_drained();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    stall_mode   = 0;
    cycle_cnt    = 0;
    mismatch_cnt = 0;
    req_cnt      = 0;
    rsp_cnt      = 0;
    burst_left   = 0;
    for (int i = 0; i < 7; i++) region_seen[i] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_triangles(250);
    test_drain_and_restart();
    test_random_triangles(260);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests, %0d responses checked in %0d cycles", req_cnt, rsp_cnt,
             cycle_cnt);
    $display("regions A %0d B %0d AB %0d C %0d AC %0d BC %0d face %0d",
             region_seen[0], region_seen[1], region_seen[2], region_seen[3],
             region_seen[4], region_seen[5], region_seen[6]);
    if (mismatch_cnt == 0 && expected_rsp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/cpt_pkg.sv
sv/cpt_div.sv
sv/closest_point_on_triangle.sv
sv/cpt_chk.sv
dv/closest_point_on_triangle_test.sv
